/* hdl/dcf_pkg.sv */
// Shared types, constants and decode functions for the DCF77 pulse time decoder.
`timescale 1ns / 1ps
`default_nettype none
package dcf_pkg;

    localparam int TIME_WIDTH_DEF = 48;

    localparam int BIT_ONE_WIDTH  = 20;
    localparam int MIN_GAP_WIDTH  = 22;
    localparam int CFG_IDX_WIDTH  = 1;
    localparam int CFG_DATA_WIDTH = MIN_GAP_WIDTH;
    localparam int SHIFT_WIDTH    = 64;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BIT_ONE_MIN = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_GAP_MIN = 1'd1;

    localparam logic [BIT_ONE_WIDTH-1:0] BIT_ONE_RESET = 20'd140000;
    localparam logic [MIN_GAP_WIDTH-1:0] MIN_GAP_RESET = 22'd1701000;

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    // Frame positions in the shift register at the time the gap is seen.
    localparam int MIN_FIELD_LSB  = 32;
    localparam int HOUR_FIELD_LSB = 25;

    localparam logic [6:0] MIN_WEIGHTS  [7] = '{7'd40, 7'd20, 7'd10, 7'd8, 7'd4, 7'd2, 7'd1};
    localparam logic [6:0] HOUR_WEIGHTS [6] = '{7'd20, 7'd10, 7'd8, 7'd4, 7'd2, 7'd1};

    typedef struct packed {
        logic [BIT_ONE_WIDTH-1:0] bit_one_min_us;
        logic [MIN_GAP_WIDTH-1:0] minute_gap_min_us;
    } t_cfg;

    typedef struct packed {
        logic [5:0] second_now;
        logic [5:0] minute_now;
        logic [4:0] hour_now;
        logic       bit_taken;
        logic       frame_done;
    } t_result;

    function automatic logic [5:0] decode_minute(input logic [6:0] field);
        logic [6:0] sum;
        sum = '0;
        for (int i = 0; i < 7; i++) begin
            if (field[i]) begin
                sum = sum + MIN_WEIGHTS[i];
            end
        end
        decode_minute = (sum > 7'(MIN_LAST)) ? 6'd0 : sum[5:0];
    endfunction

    function automatic logic [4:0] decode_hour(input logic [5:0] field);
        logic [6:0] sum;
        sum = '0;
        for (int i = 0; i < 6; i++) begin
            if (field[i]) begin
                sum = sum + HOUR_WEIGHTS[i];
            end
        end
        decode_hour = (sum > 7'(HOUR_LAST)) ? 5'd0 : sum[4:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/dcf_if.sv */
// Valid/ready channel interfaces for samples, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface dcf_in_if #(
    parameter int TIME_WIDTH = dcf_pkg::TIME_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  level;
    logic [TIME_WIDTH-1:0] time_us;

    modport source (output valid, level, time_us, input ready);
    modport sink   (input valid, level, time_us, output ready);
endinterface

interface dcf_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second_now;
    logic [5:0] minute_now;
    logic [4:0] hour_now;
    logic       bit_taken;
    logic       frame_done;

    modport source (output valid, second_now, minute_now, hour_now, bit_taken, frame_done,
                    input ready);
    modport sink   (input valid, second_now, minute_now, hour_now, bit_taken, frame_done,
                    output ready);
endinterface

interface dcf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dcf_pkg::CFG_IDX_WIDTH-1:0]  index;
    logic [dcf_pkg::CFG_DATA_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/dcf_cfg.sv */
// Configuration register file: bit-one threshold and minute gap threshold.
`timescale 1ns / 1ps
`default_nettype none
module dcf_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    dcf_cfg_if.sink             i_cfg,
    output dcf_pkg::t_cfg       o_cfg
);

    dcf_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_one_min_us    <= dcf_pkg::BIT_ONE_RESET;
            r_cfg.minute_gap_min_us <= dcf_pkg::MIN_GAP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dcf_pkg::CFG_BIT_ONE_MIN: begin
                    r_cfg.bit_one_min_us <= i_cfg.data[dcf_pkg::BIT_ONE_WIDTH-1:0];
                end
                dcf_pkg::CFG_MIN_GAP_MIN: begin
                    r_cfg.minute_gap_min_us <= i_cfg.data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* hdl/dcf_core.sv */
// Edge detection, pulse timing, bit shift register and clock counters.
`timescale 1ns / 1ps
`default_nettype none
module dcf_core #(
    parameter int TIME_WIDTH = dcf_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic                  i_level,
    input  wire logic [TIME_WIDTH-1:0] i_time_us,
    input  dcf_pkg::t_cfg              i_cfg,
    output dcf_pkg::t_result           o_result
);

    logic                                r_last_level;
    logic [TIME_WIDTH-1:0]               r_pulse_start;
    logic [TIME_WIDTH-1:0]               r_pulse_end;
    logic [dcf_pkg::SHIFT_WIDTH-1:0]     r_bit_shift;
    logic [5:0]                          r_second;
    logic [5:0]                          r_minute;
    logic [4:0]                          r_hour;

    logic                                n_last_level;
    logic [TIME_WIDTH-1:0]               n_pulse_start;
    logic [TIME_WIDTH-1:0]               n_pulse_end;
    logic [dcf_pkg::SHIFT_WIDTH-1:0]     n_bit_shift;
    logic [5:0]                          n_second;
    logic [5:0]                          n_minute;
    logic [4:0]                          n_hour;
    logic                                n_taken;
    logic                                n_done;

    logic [TIME_WIDTH-1:0]               gap;
    logic [TIME_WIDTH-1:0]               pulse_len;
    logic                                bit_one;
    logic [dcf_pkg::SHIFT_WIDTH-1:0]     shifted;

    // Differences wrap with the timestamp width.
    assign gap       = i_time_us - r_pulse_end;
    assign pulse_len = i_time_us - r_pulse_start;
    assign bit_one   = pulse_len >= TIME_WIDTH'(i_cfg.bit_one_min_us);
    assign shifted   = {r_bit_shift[dcf_pkg::SHIFT_WIDTH-2:0], bit_one};

    always_comb begin
        n_last_level  = r_last_level;
        n_pulse_start = r_pulse_start;
        n_pulse_end   = r_pulse_end;
        n_bit_shift   = r_bit_shift;
        n_second      = r_second;
        n_minute      = r_minute;
        n_hour        = r_hour;
        n_taken       = 1'b0;
        n_done        = 1'b0;
        if (i_level != r_last_level) begin
            n_last_level = i_level;
            if (!i_level) begin
                n_pulse_start = i_time_us;
            end else begin
                n_pulse_end = i_time_us;
                n_taken     = 1'b1;
                if (gap >= TIME_WIDTH'(i_cfg.minute_gap_min_us)) begin
                    // Any minute carry is overwritten by the decoded frame.
                    n_done      = 1'b1;
                    n_second    = 6'd0;
                    n_bit_shift = '0;
                    n_minute    = dcf_pkg::decode_minute(
                        shifted[dcf_pkg::MIN_FIELD_LSB +: 7]);
                    n_hour      = dcf_pkg::decode_hour(
                        shifted[dcf_pkg::HOUR_FIELD_LSB +: 6]);
                end else begin
                    n_bit_shift = shifted;
                    if (r_second == dcf_pkg::SEC_LAST) begin
                        n_second = 6'd0;
                        if (r_minute == dcf_pkg::MIN_LAST) begin
                            n_minute = 6'd0;
                            n_hour   = (r_hour == dcf_pkg::HOUR_LAST) ? 5'd0 : r_hour + 5'd1;
                        end else begin
                            n_minute = r_minute + 6'd1;
                        end
                    end else begin
                        n_second = r_second + 6'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level  <= 1'b0;
            r_pulse_start <= '0;
            r_pulse_end   <= '0;
            r_bit_shift   <= '0;
            r_second      <= 6'd0;
            r_minute      <= 6'd0;
            r_hour        <= 5'd0;
        end else if (i_accept) begin
            r_last_level  <= n_last_level;
            r_pulse_start <= n_pulse_start;
            r_pulse_end   <= n_pulse_end;
            r_bit_shift   <= n_bit_shift;
            r_second      <= n_second;
            r_minute      <= n_minute;
            r_hour        <= n_hour;
        end
    end

    assign o_result.second_now = n_second;
    assign o_result.minute_now = n_minute;
    assign o_result.hour_now   = n_hour;
    assign o_result.bit_taken  = n_taken;
    assign o_result.frame_done = n_done;

endmodule
`default_nettype wire

/* hdl/dcf77_pulse_time_decoder.sv */
// DCF77 pulse time decoder top level with its result register.
// Usage:
//   i_in carries one receiver sample per transfer: level (0 while the carrier
//   is reduced, 1 idle) and a free-running microsecond timestamp time_us.
//   o_out returns exactly one result per sample: second, minute and hour after
//   the sample, bit_taken when a pulse ended, frame_done when a minute gap
//   was seen and the time was decoded from the frame.
//   i_cfg writes index 0 (bit-one pulse length, us) or index 1 (minute gap,
//   us); it is always ready and should only be used while no sample is open.
// Output: the result of a sample is valid on o_out in the cycle after its
//   transfer. Throughput: one sample per clock while o_out is ready; all
//   the work sits in one compare-and-count stage ahead of the result register.
// Stall: when o_out is held off, the result stays in the register and i_in
//   drops ready; the next sample is taken in the same cycle the held result
//   leaves.
// Reset: synchronous, active low; clears all timing state and counters, and
//   loads the threshold registers with 140000 us and 1701000 us.
`timescale 1ns / 1ps
`default_nettype none
module dcf77_pulse_time_decoder #(
    parameter int TIME_WIDTH = dcf_pkg::TIME_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dcf_in_if.sink      i_in,
    dcf_out_if.source   o_out,
    dcf_cfg_if.sink     i_cfg
);

    dcf_pkg::t_cfg    cfg;
    dcf_pkg::t_result result;
    dcf_pkg::t_result r_out;
    logic             r_out_valid;
    logic             accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    dcf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    dcf_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_level   (i_in.level),
        .i_time_us (i_in.time_us),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.second_now = r_out.second_now;
    assign o_out.minute_now = r_out.minute_now;
    assign o_out.hour_now   = r_out.hour_now;
    assign o_out.bit_taken  = r_out.bit_taken;
    assign o_out.frame_done = r_out.frame_done;

    a_accept_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted sample produced no result");

    a_done_implies_taken : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_done) |-> o_out.bit_taken)
        else $error("frame end without a pulse end");

    a_done_clears_second : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_done) |-> (o_out.second_now == 6'd0))
        else $error("second not cleared at frame end");

    a_time_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.second_now <= dcf_pkg::SEC_LAST
                         && o_out.minute_now <= dcf_pkg::MIN_LAST
                         && o_out.hour_now <= dcf_pkg::HOUR_LAST))
        else $error("time count out of range");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !accept)
        else $error("held result overwritten");

endmodule
`default_nettype wire
